### hdl/tct_pkg.sv
// shared types and constants for the touch contact tracker
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;
    localparam int DefMaxPoints = 10;
    localparam logic [31:0] DefStaleTimeout = 32'd2000;

    localparam logic [2:0] FUNC_DOWN   = 3'd0;
    localparam logic [2:0] FUNC_MOVE   = 3'd1;
    localparam logic [2:0] FUNC_UP     = 3'd2;
    localparam logic [2:0] FUNC_CANCEL = 3'd3;
    localparam logic [2:0] FUNC_TICK   = 3'd4;

    localparam logic [2:0] EV_DOWN   = 3'd0;
    localparam logic [2:0] EV_MOVE   = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_CANCEL = 3'd3;
    localparam logic [2:0] EV_STALE  = 3'd4;

    // result source selection
    localparam logic [2:0] RS_DOWN     = 3'd0;
    localparam logic [2:0] RS_MOVE     = 3'd1;
    localparam logic [2:0] RS_UP_SLOT  = 3'd2;
    localparam logic [2:0] RS_UP_ZERO  = 3'd3;
    localparam logic [2:0] RS_CANCEL   = 3'd4;
    localparam logic [2:0] RS_STALE    = 3'd5;

    // slot write operations
    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_DOWN    = 3'd1;
    localparam logic [2:0] WR_MOVE    = 3'd2;
    localparam logic [2:0] WR_UP      = 3'd3;
    localparam logic [2:0] WR_CANCEL  = 3'd4;
    localparam logic [2:0] WR_STALE   = 3'd5;
    localparam logic [2:0] WR_REMOVE  = 3'd6;

    typedef struct packed {
        logic       load;     // capture input item
        logic       ptr_load; // ptr <= 0
        logic       ptr_inc;
        logic       ptr_top;  // ptr <= count - 1
        logic       ptr_dec;
        logic       cnt_inc;  // append at count
        logic [2:0] wr_op;    // write slot at ptr (or count for append)
        logic       wr_at_count;
        logic       emit;
        logic       hold;     // capture result without raising valid
        logic       flush;    // raise valid on the held result
        logic [2:0] rsel;
        logic       emit_last;
    } tct_cmd_t;

    typedef struct packed {
        logic       match;     // slot at ptr holds item id
        logic       ptr_end;   // ptr >= count
        logic       ptr_zero;
        logic       full;
        logic       f_down;
        logic       f_stale;
        logic       f_pend;
        logic       aged;      // time nonzero and idle beyond timeout
        logic       count_zero;
        logic [2:0] func;
        logic       out_busy;  // output register holds a result
    } tct_stat_t;
endpackage
`default_nettype wire

### hdl/tct_datapath.sv
// slot storage, search pointer and result register
`timescale 1ns / 1ps
`default_nettype none
module tct_datapath
    import tct_pkg::*;
#(
    parameter int MAX_POINTS = DefMaxPoints
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tct_cmd_t           cmd,
    output tct_stat_t               stat,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic [2:0]         s_func,
    input  wire logic [4:0]         s_pointer_id,
    input  wire logic signed [15:0] s_pos_x,
    input  wire logic signed [15:0] s_pos_y,
    input  wire logic [7:0]         s_pressure,
    input  wire logic [31:0]        s_time_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_event_kind,
    output logic [4:0]              m_touch_id,
    output logic signed [15:0]      m_out_x,
    output logic signed [15:0]      m_out_y,
    output logic signed [16:0]      m_delta_x,
    output logic signed [16:0]      m_delta_y,
    output logic [7:0]              m_out_pressure,
    output logic                    m_last
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [4:0]  mem_id [MAX_POINTS];
    logic [15:0] mem_x [MAX_POINTS];
    logic [15:0] mem_y [MAX_POINTS];
    logic [7:0]  mem_pr [MAX_POINTS];
    logic [31:0] mem_t [MAX_POINTS];
    logic [2:0]  mem_f [MAX_POINTS];

    logic [31:0] timeout_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [2:0]  func_reg;
    logic [4:0]  id_reg;
    logic [15:0] x_reg, y_reg;
    logic [7:0]  pr_reg;
    logic [31:0] t_reg;

    logic [IW-1:0] rd_idx, wr_idx, last_idx;
    logic [4:0]  c_id;
    logic [15:0] c_x, c_y;
    logic [31:0] c_t;
    logic [2:0]  c_f;
    logic [31:0] idle;
    logic        ptr_ok;

    assign ptr_ok   = ptr_reg < count_reg;
    assign rd_idx   = ptr_ok ? ptr_reg[IW-1:0] : '0;
    assign last_idx = (count_reg != '0) ? IW'(count_reg - 1'b1) : '0;
    assign wr_idx   = cmd.wr_at_count ? IW'(count_reg) : rd_idx;
    assign c_id = mem_id[rd_idx];
    assign c_x  = mem_x[rd_idx];
    assign c_y  = mem_y[rd_idx];
    assign c_t  = mem_t[rd_idx];
    assign c_f  = mem_f[rd_idx];
    assign idle = t_reg - c_t;

    always_comb begin
        stat.match      = ptr_ok && (c_id == id_reg);
        stat.ptr_end    = !ptr_ok;
        stat.ptr_zero   = ptr_reg == '0;
        stat.full       = count_reg >= CW'(MAX_POINTS);
        stat.f_down     = c_f[0];
        stat.f_stale    = c_f[1];
        stat.f_pend     = c_f[2];
        stat.aged       = (c_t != '0) && (idle > timeout_reg);
        stat.count_zero = count_reg == '0;
        stat.func       = func_reg;
        stat.out_busy   = m_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= DefStaleTimeout;
            count_reg   <= '0;
            ptr_reg     <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.ptr_load) begin
                ptr_reg <= '0;
            end else if (cmd.ptr_inc) begin
                ptr_reg <= ptr_reg + 1'b1;
            end else if (cmd.ptr_top) begin
                ptr_reg <= count_reg - 1'b1;
            end else if (cmd.ptr_dec) begin
                ptr_reg <= ptr_reg - 1'b1;
            end
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.wr_op == WR_REMOVE) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            id_reg   <= s_pointer_id;
            x_reg    <= s_pos_x;
            y_reg    <= s_pos_y;
            pr_reg   <= s_pressure;
            t_reg    <= s_time_ms;
        end
        case (cmd.wr_op)
            WR_DOWN: begin
                mem_id[wr_idx] <= id_reg;
                mem_x[wr_idx]  <= x_reg;
                mem_y[wr_idx]  <= y_reg;
                mem_pr[wr_idx] <= pr_reg;
                mem_t[wr_idx]  <= t_reg;
                mem_f[wr_idx]  <= 3'b001;
            end
            WR_MOVE: begin
                mem_x[wr_idx]  <= x_reg;
                mem_y[wr_idx]  <= y_reg;
                mem_pr[wr_idx] <= pr_reg;
                mem_t[wr_idx]  <= t_reg;
                mem_f[wr_idx]  <= c_f & 3'b101;
            end
            WR_UP: begin
                mem_t[wr_idx] <= t_reg;
                mem_f[wr_idx] <= (c_f & 3'b110) | 3'b100;
            end
            WR_CANCEL: begin
                mem_f[wr_idx] <= (c_f & 3'b110) | 3'b100;
            end
            WR_STALE: begin
                mem_f[wr_idx] <= c_f | 3'b010;
            end
            WR_REMOVE: begin
                mem_id[wr_idx] <= mem_id[last_idx];
                mem_x[wr_idx]  <= mem_x[last_idx];
                mem_y[wr_idx]  <= mem_y[last_idx];
                mem_pr[wr_idx] <= mem_pr[last_idx];
                mem_t[wr_idx]  <= mem_t[last_idx];
                mem_f[wr_idx]  <= mem_f[last_idx];
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if ((cmd.emit && !cmd.hold) || cmd.flush) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_last         <= cmd.emit_last;
            m_touch_id     <= id_reg;
            m_out_x        <= '0;
            m_out_y        <= '0;
            m_delta_x      <= '0;
            m_delta_y      <= '0;
            m_out_pressure <= '0;
            case (cmd.rsel)
                RS_DOWN: begin
                    m_event_kind   <= EV_DOWN;
                    m_out_x        <= x_reg;
                    m_out_y        <= y_reg;
                    m_out_pressure <= pr_reg;
                end
                RS_MOVE: begin
                    m_event_kind   <= EV_MOVE;
                    m_out_x        <= x_reg;
                    m_out_y        <= y_reg;
                    m_delta_x      <= {x_reg[15], x_reg} - {c_x[15], c_x};
                    m_delta_y      <= {y_reg[15], y_reg} - {c_y[15], c_y};
                    m_out_pressure <= pr_reg;
                end
                RS_UP_SLOT: begin
                    m_event_kind <= EV_UP;
                    m_touch_id   <= c_id;
                    m_out_x      <= c_x;
                    m_out_y      <= c_y;
                end
                RS_UP_ZERO: begin
                    m_event_kind <= EV_UP;
                end
                RS_CANCEL: begin
                    m_event_kind <= EV_CANCEL;
                    m_touch_id   <= '0;
                end
                default: begin
                    m_event_kind <= EV_STALE;
                    m_touch_id   <= c_id;
                end
            endcase
        end else if (cmd.flush) begin
            m_last <= cmd.emit_last;
        end
    end
endmodule
`default_nettype wire

### hdl/tct_ctrl.sv
// sequencing state machine for the touch contact tracker
`timescale 1ns / 1ps
`default_nettype none
module tct_ctrl
    import tct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire tct_stat_t stat,
    output tct_cmd_t       cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DOWN2  = 3'd2;
    localparam logic [2:0] ST_CANCEL = 3'd3;
    localparam logic [2:0] ST_AGE    = 3'd4;
    localparam logic [2:0] ST_PTOP   = 3'd5;
    localparam logic [2:0] ST_PURGE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       pend_reg, pend_next; // tick result held in the result register
    logic       wait_out;

    assign wait_out = stat.out_busy;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    cmd.ptr_load = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                case (stat.func) inside
                    FUNC_CANCEL: begin
                        state_next = ST_CANCEL;
                    end
                    FUNC_TICK: begin
                        pend_next  = 1'b0;
                        cmd.ptr_top = 1'b1;
                        state_next = stat.count_zero ? ST_IDLE : ST_AGE;
                    end
                    FUNC_DOWN, FUNC_MOVE, FUNC_UP: begin
                        if (stat.match) begin
                            if (!wait_out) begin
                                if (stat.func == FUNC_DOWN) begin
                                    if (stat.f_down) begin
                                        cmd.emit = 1'b1;
                                        cmd.rsel = RS_UP_SLOT;
                                    end
                                    state_next = ST_DOWN2;
                                end else if (stat.func == FUNC_MOVE) begin
                                    if (stat.f_down) begin
                                        cmd.emit      = 1'b1;
                                        cmd.rsel      = RS_MOVE;
                                        cmd.emit_last = 1'b1;
                                        cmd.wr_op     = WR_MOVE;
                                    end
                                    state_next = ST_IDLE;
                                end else begin
                                    cmd.emit      = 1'b1;
                                    cmd.rsel      = RS_UP_SLOT;
                                    cmd.emit_last = 1'b1;
                                    cmd.wr_op     = WR_UP;
                                    state_next    = ST_IDLE;
                                end
                            end
                        end else if (stat.ptr_end) begin
                            if (!wait_out) begin
                                if (stat.func == FUNC_DOWN) begin
                                    cmd.emit      = 1'b1;
                                    cmd.rsel      = RS_DOWN;
                                    cmd.emit_last = 1'b1;
                                    if (!stat.full) begin
                                        cmd.wr_op       = WR_DOWN;
                                        cmd.wr_at_count = 1'b1;
                                        cmd.cnt_inc     = 1'b1;
                                    end
                                end else if (stat.func == FUNC_UP) begin
                                    cmd.emit      = 1'b1;
                                    cmd.rsel      = RS_UP_ZERO;
                                    cmd.emit_last = 1'b1;
                                end
                                state_next = ST_IDLE;
                            end
                        end else begin
                            cmd.ptr_inc = 1'b1;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DOWN2: begin
                if (!wait_out) begin
                    cmd.emit      = 1'b1;
                    cmd.rsel      = RS_DOWN;
                    cmd.emit_last = 1'b1;
                    cmd.wr_op     = WR_DOWN;
                    state_next    = ST_IDLE;
                end
            end
            ST_CANCEL: begin
                if (stat.ptr_end) begin
                    if (!wait_out) begin
                        cmd.emit      = 1'b1;
                        cmd.rsel      = RS_CANCEL;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.wr_op   = WR_CANCEL;
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_AGE: begin
                // pointer walks down; stalls while a result waits
                if (stat.ptr_end || stat.f_pend || !stat.aged) begin
                    if (stat.ptr_zero) begin
                        state_next = ST_PTOP;
                    end else begin
                        cmd.ptr_dec = 1'b1;
                    end
                end else if (pend_reg) begin
                    cmd.flush = 1'b1;
                    pend_next = 1'b0;
                end else if (!wait_out) begin
                    cmd.emit  = 1'b1;
                    cmd.hold  = 1'b1;
                    pend_next = 1'b1;
                    if (!stat.f_stale) begin
                        cmd.rsel  = RS_STALE;
                        cmd.wr_op = WR_STALE;
                    end else begin
                        cmd.rsel  = RS_UP_SLOT;
                        cmd.wr_op = WR_REMOVE;
                    end
                    if (stat.ptr_zero) begin
                        state_next = ST_PTOP;
                    end else begin
                        cmd.ptr_dec = 1'b1;
                    end
                end
            end
            ST_PTOP: begin
                // held tick result goes out as the last one
                if (pend_reg) begin
                    cmd.flush     = 1'b1;
                    cmd.emit_last = 1'b1;
                    pend_next     = 1'b0;
                end
                cmd.ptr_top = 1'b1;
                state_next  = stat.count_zero ? ST_IDLE : ST_PURGE;
            end
            ST_PURGE: begin
                if (!stat.ptr_end && stat.f_pend) begin
                    cmd.wr_op = WR_REMOVE;
                end
                if (stat.ptr_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.ptr_dec = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end
endmodule
`default_nettype wire

### hdl/touch_contact_tracker_unit.sv
// touch contact tracker top level
// one item at a time; a search steps the slot pointer through the slots, a tick walks
//   them down to age and again to purge; tick results are held one deep to mark the last
// reset: synchronous active low; clears slot count, state and timeout to 2000
// slot storage has no reset, entries beyond the count are never read
`timescale 1ns / 1ps
`default_nettype none
module touch_contact_tracker_unit
    import tct_pkg::*;
#(
    parameter int MAX_POINTS = DefMaxPoints
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_func,
    input  wire logic [4:0]         s_pointer_id,
    input  wire logic signed [15:0] s_pos_x,
    input  wire logic signed [15:0] s_pos_y,
    input  wire logic [7:0]         s_pressure,
    input  wire logic [31:0]        s_time_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_event_kind,
    output logic [4:0]              m_touch_id,
    output logic signed [15:0]      m_out_x,
    output logic signed [15:0]      m_out_y,
    output logic signed [16:0]      m_delta_x,
    output logic signed [16:0]      m_delta_y,
    output logic [7:0]              m_out_pressure,
    output logic                    m_last
);
    tct_cmd_t  cmd;
    tct_stat_t stat;

    tct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tct_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_func         (s_func),
        .s_pointer_id   (s_pointer_id),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pressure     (s_pressure),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_touch_id     (m_touch_id),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_delta_x      (m_delta_x),
        .m_delta_y      (m_delta_y),
        .m_out_pressure (m_out_pressure),
        .m_last         (m_last)
    );

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready || cmd.rsel == RS_DOWN))
        else $error("result overwritten");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");
    a_flush_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> !m_valid)
        else $error("held result released over a valid one");
`endif
endmodule
`default_nettype wire

### sim/tct_checker.sv
// checker: predicts touch tracker reports and compares them at the result port
`timescale 1ns / 1ps
module tct_checker
    import tct_pkg::*;
#(
    parameter int MAX_POINTS = DefMaxPoints
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [2:0]         s_func,
    input  wire logic [4:0]         s_pointer_id,
    input  wire logic signed [15:0] s_pos_x,
    input  wire logic signed [15:0] s_pos_y,
    input  wire logic [7:0]         s_pressure,
    input  wire logic [31:0]        s_time_ms,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [2:0]         m_event_kind,
    input  wire logic [4:0]         m_touch_id,
    input  wire logic signed [15:0] m_out_x,
    input  wire logic signed [15:0] m_out_y,
    input  wire logic signed [16:0] m_delta_x,
    input  wire logic signed [16:0] m_delta_y,
    input  wire logic [7:0]         m_out_pressure,
    input  wire logic               m_last,
    output int                      fail_count,
    output int                      pending_reports
);
    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [7:0]         pr;
        logic               last;
    } report_t;

    localparam logic [2:0] FL_DOWN = 3'b001;
    localparam logic [2:0] FL_STALE = 3'b010;
    localparam logic [2:0] FL_PEND = 3'b100;

    report_t            report_q[$];
    logic [31:0]        timeout;
    logic [4:0]         c_id[MAX_POINTS];
    logic signed [15:0] c_x[MAX_POINTS];
    logic signed [15:0] c_y[MAX_POINTS];
    logic [7:0]         c_pr[MAX_POINTS];
    logic [31:0]        c_time[MAX_POINTS];
    logic [2:0]         c_fl[MAX_POINTS];
    int                 c_count;
    int                 gen_n;

    assign pending_reports = report_q.size();

    function automatic int find_contact(logic [4:0] id);
        for (int i = 0; i < c_count; i++) if (c_id[i] == id) return i;
        return -1;
    endfunction

    task automatic drop_contact(int k);
        int l;
        l = c_count - 1;
        if (k < l) begin
            c_id[k] = c_id[l]; c_x[k] = c_x[l]; c_y[k] = c_y[l];
            c_pr[k] = c_pr[l]; c_time[k] = c_time[l]; c_fl[k] = c_fl[l];
        end
        c_count = l;
    endtask

    task automatic push_report(logic [2:0] kind, logic [4:0] id, logic signed [15:0] x,
                               logic signed [15:0] y, logic signed [16:0] dx,
                               logic signed [16:0] dy, logic [7:0] pr);
        report_t r;
        if (gen_n > 0) report_q[report_q.size() - 1].last = 1'b0;
        r = '{kind, id, x, y, dx, dy, pr, 1'b1};
        report_q = {report_q, r};
        gen_n++;
    endtask

    task automatic track_event(logic [2:0] f, logic [4:0] id, logic signed [15:0] x,
                               logic signed [15:0] y, logic [7:0] pr, logic [31:0] t);
        int s;
        logic signed [16:0] dx, dy;
        gen_n = 0;
        case (f)
            FUNC_DOWN: begin
                s = find_contact(id);
                if (s < 0 && c_count < MAX_POINTS) begin
                    s = c_count; c_count++; c_id[s] = id; c_fl[s] = '0;
                end else if (s >= 0 && c_fl[s][0]) begin
                    push_report(EV_UP, id, c_x[s], c_y[s], '0, '0, '0);
                end
                if (s >= 0) begin
                    c_x[s] = x; c_y[s] = y; c_pr[s] = pr; c_time[s] = t; c_fl[s] = FL_DOWN;
                end
                push_report(EV_DOWN, id, x, y, '0, '0, pr);
            end
            FUNC_MOVE: begin
                s = find_contact(id);
                if (s >= 0 && c_fl[s][0]) begin
                    dx = 17'(x) - 17'(c_x[s]);
                    dy = 17'(y) - 17'(c_y[s]);
                    c_x[s] = x; c_y[s] = y; c_pr[s] = pr; c_time[s] = t;
                    c_fl[s] = c_fl[s] & ~FL_STALE;
                    push_report(EV_MOVE, id, x, y, dx, dy, pr);
                end
            end
            FUNC_UP: begin
                s = find_contact(id);
                if (s >= 0) begin
                    push_report(EV_UP, id, c_x[s], c_y[s], '0, '0, '0);
                    c_time[s] = t; c_fl[s] = (c_fl[s] & ~FL_DOWN) | FL_PEND;
                end else begin
                    push_report(EV_UP, id, '0, '0, '0, '0, '0);
                end
            end
            FUNC_CANCEL: begin
                for (int i = 0; i < c_count; i++) c_fl[i] = (c_fl[i] & ~FL_DOWN) | FL_PEND;
                push_report(EV_CANCEL, '0, '0, '0, '0, '0, '0);
            end
            FUNC_TICK: begin
                for (int k = c_count - 1; k >= 0; k--) begin
                    if (k >= c_count) continue;
                    if (c_time[k] == 0 || c_fl[k][2]) continue;
                    if (32'(t - c_time[k]) > timeout) begin
                        if (!c_fl[k][1]) begin
                            c_fl[k] = c_fl[k] | FL_STALE;
                            push_report(EV_STALE, c_id[k], '0, '0, '0, '0, '0);
                        end else begin
                            push_report(EV_UP, c_id[k], c_x[k], c_y[k], '0, '0, '0);
                            drop_contact(k);
                        end
                    end
                end
                for (int k = c_count - 1; k >= 0; k--)
                    if (k < c_count && c_fl[k][2]) drop_contact(k);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        report_t got, want;
        if (!aresetn) begin
            timeout <= DefStaleTimeout;
            c_count = 0;
            fail_count <= 0;
        end else begin
            if (cfg_we) timeout <= cfg_wdata;
            if (s_valid && s_ready)
                track_event(s_func, s_pointer_id, s_pos_x, s_pos_y, s_pressure, s_time_ms);
            if (m_valid && m_ready) begin
                got = '{m_event_kind, m_touch_id, m_out_x, m_out_y, m_delta_x, m_delta_y,
                        m_out_pressure, m_last};
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = report_q.pop_front();
                    if (got != want) begin
                        $display("%0t: report mismatch, expected %p, actual %p",
                                 $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/tb.sv
// testbench top: stimulus for the touch contact tracker and the verdict
`timescale 1ns / 1ps
module tb
    import tct_pkg::*;
;
    localparam int CycleLimit = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func = '0;
    logic [4:0]         s_pointer_id = '0;
    logic signed [15:0] s_pos_x = '0;
    logic signed [15:0] s_pos_y = '0;
    logic [7:0]         s_pressure = '0;
    logic [31:0]        s_time_ms = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_event_kind;
    logic [4:0]         m_touch_id;
    logic signed [15:0] m_out_x, m_out_y;
    logic signed [16:0] m_delta_x, m_delta_y;
    logic [7:0]         m_out_pressure;
    logic               m_last;
    int                 fail_count, pending_reports;
    int                 cycles = 0;
    logic               calm = 1'b0;
    logic               hold_sink = 1'b0;
    logic [31:0]        now_ms = 32'd100;

    always #1 aclk = ~aclk;

    touch_contact_tracker_unit i_dut (.*);
    tct_checker i_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall bursts, or a long hold-off when asked
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (gap - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [2:0] f, logic [4:0] id, logic [15:0] x, logic [15:0] y,
                             logic [7:0] pr, logic [31:0] t);
        if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 17)) @(posedge aclk);
        s_valid <= 1'b1;
        s_func <= f; s_pointer_id <= id; s_pos_x <= x; s_pos_y <= y;
        s_pressure <= pr; s_time_ms <= t;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_and_config(logic [31:0] v);
        while (pending_reports != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item(int ids);
        int r;
        logic [2:0] f;
        r = $urandom_range(0, 99);
        now_ms = now_ms + $urandom_range(0, 1500);
        if (r < 30) f = FUNC_DOWN;
        else if (r < 60) f = FUNC_MOVE;
        else if (r < 75) f = FUNC_UP;
        else if (r < 79) f = FUNC_CANCEL;
        else if (r < 96) f = FUNC_TICK;
        else f = 3'($urandom_range(5, 7));
        send_item(f, 5'($urandom_range(0, ids - 1)), 16'($urandom), 16'($urandom),
                  8'($urandom), ($urandom_range(0, 30) == 0) ? 32'd0 : now_ms);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes, every operation, known and unknown ids
        send_item(FUNC_UP, 5'd31, 16'h0, 16'h0, 8'h0, 32'd1);
        send_item(FUNC_MOVE, 5'd3, 16'h1, 16'h1, 8'h1, 32'd1);
        send_item(FUNC_DOWN, 5'd0, 16'h8000, 16'h7fff, 8'hff, 32'd10);
        send_item(FUNC_MOVE, 5'd0, 16'h7fff, 16'h8000, 8'h00, 32'd20);
        send_item(FUNC_DOWN, 5'd0, 16'h1234, 16'hfedc, 8'h80, 32'd30);
        send_item(FUNC_DOWN, 5'd31, 16'h7fff, 16'h8000, 8'h00, 32'd0);
        send_item(FUNC_UP, 5'd0, 16'h0, 16'h0, 8'h0, 32'd40);
        send_item(FUNC_MOVE, 5'd0, 16'h5, 16'h5, 8'h5, 32'd41);
        send_item(3'd5, 5'd1, 16'h0, 16'h0, 8'h0, 32'd0);
        send_item(3'd7, 5'd2, 16'hffff, 16'hffff, 8'hff, 32'hffffffff);
        for (int i = 1; i <= 11; i++)
            send_item(FUNC_DOWN, 5'(i), 16'(i * 300), 16'(-i * 200), 8'(i), 32'hfffffff0);
        send_item(FUNC_TICK, 5'd0, 16'h0, 16'h0, 8'h0, 32'd3000);
        send_item(FUNC_TICK, 5'd0, 16'h0, 16'h0, 8'h0, 32'd3001);
        send_item(FUNC_CANCEL, 5'd0, 16'h0, 16'h0, 8'h0, 32'd3002);
        send_item(FUNC_TICK, 5'd0, 16'h0, 16'h0, 8'h0, 32'hffffffff);

        drain_and_config(32'd0);
        for (int i = 0; i < 10; i++)
            send_item(FUNC_DOWN, 5'(i * 3), 16'($urandom), 16'($urandom), 8'($urandom), 32'd5);
        hold_sink <= 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_sink <= 1'b0;
            end
        join_none
        for (int i = 0; i < 8; i++) random_item(32);
        for (int i = 0; i < 40; i++) random_item(12);

        drain_and_config(32'hffffffff);
        for (int i = 0; i < 40; i++) random_item(16);

        drain_and_config(32'd700);
        for (int i = 0; i < 25; i++) random_item(12);

        drain_and_config(32'd1500);
        calm <= 1'b1;
        for (int i = 0; i < 40; i++) random_item(32);

        while (pending_reports != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
